// ----- rtl/core/mclf_pkg.sv -----
// ----------------------------------------------------------------------------
// mclf_pkg
// Shared codes, widths and handshake structs for the linear fade engine.
// ----------------------------------------------------------------------------
package mclf_pkg;

    // Operation codes carried on the operation port
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_SET   = 3'd2;
    localparam logic [2:0] OP_FADE  = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam int LEVEL_W = 8;
    localparam int STEPS_W = 16;
    localparam int DELAY_W = 16;

    // Serial divider geometry
    localparam int DIVD_W = 17;   // dividend / quotient width
    localparam int DIVS_W = 16;   // divisor width
    localparam int DCNT_W = 5;    // iteration counter width

    localparam logic [DCNT_W-1:0] TICK_DIV_BITS = 5'd8;
    localparam logic [DCNT_W-1:0] FADE_DIV_BITS = 5'd17;

    typedef struct packed {
        logic              start;
        logic [DCNT_W-1:0] count;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/core/mclf_div.sv -----
// ----------------------------------------------------------------------------
// mclf_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module mclf_div (
    input  logic              clk,
    input  logic              rst_n,
    input  mclf_pkg::div_req_t req,
    output mclf_pkg::div_rsp_t rsp
);

    logic [mclf_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic [mclf_pkg::DIVS_W-1:0] rem_reg, rem_next;
    logic [mclf_pkg::DIVD_W-1:0] quo_reg, quo_next;
    logic [mclf_pkg::DIVS_W-1:0] dvs_reg, dvs_next;
    logic                        done_reg, done_next;

    logic [mclf_pkg::DIVS_W:0]   trial;
    logic [mclf_pkg::DIVS_W:0]   trial_sub;
    logic                        fits;

    // Shift the next dividend bit into the partial remainder
    assign trial     = {rem_reg, quo_reg[mclf_pkg::DIVD_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            cnt_next = req.count;
            rem_next = '0;
            quo_next = req.dividend;
            dvs_next = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? trial_sub[mclf_pkg::DIVS_W-1:0]
                             : trial[mclf_pkg::DIVS_W-1:0];
            quo_next  = {quo_reg[mclf_pkg::DIVD_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == mclf_pkg::DCNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- rtl/core/multi_channel_linear_fade.sv -----
// ----------------------------------------------------------------------------
// multi_channel_linear_fade
// Per-channel linear brightness fade engine with a shared bit-serial divider.
// ----------------------------------------------------------------------------
// write_level and set_target complete without leaving idle; a query beat appears
//   in the cycle after accept. start_fade stays busy through a 17-bit serial
//   divide of the duration by STEP_TICKS, one bit per cycle.
// A tick emits CHANNELS beats, one per channel; a channel that steps first waits
//   on an 8-bit serial divide.
// Reset clears every channel state and the sequencer; results cannot stall.
// ----------------------------------------------------------------------------
module multi_channel_linear_fade #(
    parameter int CHANNELS   = 4,
    parameter int STEP_TICKS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [3:0]  channel,
    input  logic        query_all,
    input  logic [7:0]  target_level,
    input  logic [15:0] duration_ms,
    input  logic [15:0] initial_delay,
    input  logic [7:0]  new_level,
    output logic        strobe,
    output logic [3:0]  channel_out,
    output logic [7:0]  level_out,
    output logic        any_changed,
    output logic        fade_done,
    output logic        last_result
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FDIV,
        S_TCHK,
        S_TDIV
    } state_t;

    // ------------------------------------------------------------------
    // Per-channel state. Delay is held as a plain down-counter: a channel
    // steps on the tick that finds it at zero, which matches a signed
    // counter stepping when it drops below zero.
    // ------------------------------------------------------------------
    logic [mclf_pkg::LEVEL_W-1:0] level_reg  [CHANNELS];
    logic [mclf_pkg::LEVEL_W-1:0] target_reg [CHANNELS];
    logic [mclf_pkg::DELAY_W-1:0] delay_reg  [CHANNELS];
    logic [mclf_pkg::STEPS_W-1:0] steps_reg  [CHANNELS];

    state_t                state_reg, state_next;
    logic [CH_IDX_W-1:0]   idx_reg, idx_next;
    logic [CH_IDX_W-1:0]   fch_reg, fch_next;
    logic                  chg_reg, chg_next;
    logic                  strobe_reg, strobe_next;
    logic [3:0]            chout_reg, chout_next;
    logic [7:0]            lvlout_reg, lvlout_next;
    logic                  anych_reg, anych_next;
    logic                  done_reg, done_next;
    logic                  last_reg, last_next;

    // Array write port: one channel per cycle
    logic [CH_IDX_W-1:0]          wr_idx;
    logic                         lvl_we, tgt_we, dly_we, stp_we;
    logic [mclf_pkg::LEVEL_W-1:0] lvl_wdata, tgt_wdata;
    logic [mclf_pkg::DELAY_W-1:0] dly_wdata;
    logic [mclf_pkg::STEPS_W-1:0] stp_wdata;

    // Array read port
    logic [CH_IDX_W-1:0]          rd_idx;
    logic [mclf_pkg::LEVEL_W-1:0] rd_level, rd_target;
    logic [mclf_pkg::DELAY_W-1:0] rd_delay;
    logic [mclf_pkg::STEPS_W-1:0] rd_steps;

    logic                         accept;
    logic [CH_IDX_W-1:0]          ch_idx;
    logic                         chan_ok;
    logic                         any_active;
    logic                         last_ch;
    logic                         move_down;
    logic [mclf_pkg::LEVEL_W-1:0] move_mag;
    logic [mclf_pkg::LEVEL_W-1:0] step_q;
    logic [mclf_pkg::DIVD_W-1:0]  fade_dividend;
    logic [mclf_pkg::STEPS_W-1:0] fade_steps;

    mclf_pkg::div_req_t div_req;
    mclf_pkg::div_rsp_t div_rsp;

    mclf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign ch_idx  = channel[CH_IDX_W-1:0];
    assign chan_ok = ({1'b0, channel} < 5'(CHANNELS));
    assign last_ch = (idx_reg == CH_IDX_W'(CHANNELS - 1));

    // Idle reads follow the addressed channel; a tick walks idx_reg
    assign rd_idx    = (state_reg == S_IDLE) ? ch_idx : idx_reg;
    assign rd_level  = level_reg[rd_idx];
    assign rd_target = target_reg[rd_idx];
    assign rd_delay  = delay_reg[rd_idx];
    assign rd_steps  = steps_reg[rd_idx];

    // Signed move split into direction and magnitude for the unsigned divider
    assign move_down = (rd_target < rd_level);
    assign move_mag  = move_down ? (rd_level - rd_target) : (rd_target - rd_level);
    assign step_q    = div_rsp.quotient[mclf_pkg::LEVEL_W-1:0];

    // ceil(duration / STEP_TICKS); a zero duration still takes one step
    assign fade_dividend = mclf_pkg::DIVD_W'(duration_ms)
                         + mclf_pkg::DIVD_W'(STEP_TICKS - 1);
    assign fade_steps    = (div_rsp.quotient == '0) ? mclf_pkg::STEPS_W'(1)
                         : div_rsp.quotient[mclf_pkg::STEPS_W-1:0];

    always_comb
    begin
        any_active = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            any_active = any_active | (steps_reg[i] != '0);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        fch_next    = fch_reg;
        chg_next    = chg_reg;
        strobe_next = 1'b0;
        chout_next  = '0;
        lvlout_next = '0;
        anych_next  = 1'b0;
        done_next   = 1'b0;
        last_next   = 1'b0;

        wr_idx    = idx_reg;
        lvl_we    = 1'b0;
        tgt_we    = 1'b0;
        dly_we    = 1'b0;
        stp_we    = 1'b0;
        lvl_wdata = rd_level;
        tgt_wdata = target_level;
        dly_wdata = initial_delay;
        stp_wdata = '0;

        div_req.start    = 1'b0;
        div_req.count    = mclf_pkg::TICK_DIV_BITS;
        div_req.dividend = {move_mag, {(mclf_pkg::DIVD_W - mclf_pkg::LEVEL_W){1'b0}}};
        div_req.divisor  = rd_steps;

        case (state_reg)
            S_IDLE:
            begin
                wr_idx = ch_idx;
                if (accept)
                begin
                    case (operation)
                        mclf_pkg::OP_TICK:
                        begin
                            idx_next   = '0;
                            chg_next   = 1'b0;
                            state_next = S_TCHK;
                        end
                        mclf_pkg::OP_WRITE:
                        begin
                            lvl_we    = chan_ok;
                            lvl_wdata = new_level;
                        end
                        mclf_pkg::OP_SET:
                        begin
                            // Load target and delay, cancel any fade
                            tgt_we = chan_ok;
                            dly_we = chan_ok;
                            stp_we = chan_ok;
                        end
                        mclf_pkg::OP_FADE:
                        begin
                            if (chan_ok)
                            begin
                                tgt_we           = 1'b1;
                                dly_we           = 1'b1;
                                fch_next         = ch_idx;
                                div_req.start    = 1'b1;
                                div_req.count    = mclf_pkg::FADE_DIV_BITS;
                                div_req.dividend = fade_dividend;
                                div_req.divisor  = mclf_pkg::DIVS_W'(STEP_TICKS);
                                state_next       = S_FDIV;
                            end
                        end
                        mclf_pkg::OP_QUERY:
                        begin
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                            if (query_all)
                            begin
                                done_next = !any_active;
                            end
                            else if (chan_ok)
                            begin
                                chout_next  = channel;
                                lvlout_next = rd_level;
                                done_next   = (rd_steps == '0);
                            end
                            else
                            begin
                                chout_next = channel;
                                done_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_FDIV:
            begin
                // Hold until the step count is known, then store it
                wr_idx = fch_reg;
                if (div_rsp.done)
                begin
                    stp_we     = 1'b1;
                    stp_wdata  = fade_steps;
                    state_next = S_IDLE;
                end
            end

            S_TCHK:
            begin
                if ((rd_steps != '0) && (rd_delay == '0))
                begin
                    // Due to step: divide the gap by the steps left
                    div_req.start = 1'b1;
                    state_next    = S_TDIV;
                end
                else
                begin
                    if (rd_steps != '0)
                    begin
                        dly_we    = 1'b1;
                        dly_wdata = rd_delay - 1'b1;
                    end
                    strobe_next = 1'b1;
                    chout_next  = 4'(idx_reg);
                    lvlout_next = rd_level;
                    anych_next  = last_ch && chg_reg;
                    last_next   = last_ch;
                    if (last_ch)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            S_TDIV:
            begin
                if (div_rsp.done)
                begin
                    lvl_we    = 1'b1;
                    lvl_wdata = move_down ? (rd_level - step_q) : (rd_level + step_q);
                    stp_we    = 1'b1;
                    stp_wdata = rd_steps - 1'b1;
                    dly_we    = 1'b1;
                    dly_wdata = mclf_pkg::DELAY_W'(STEP_TICKS);
                    chg_next  = 1'b1;

                    strobe_next = 1'b1;
                    chout_next  = 4'(idx_reg);
                    lvlout_next = lvl_wdata;
                    anych_next  = last_ch;
                    last_next   = last_ch;
                    if (last_ch)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_TCHK;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            fch_reg    <= '0;
            chg_reg    <= 1'b0;
            strobe_reg <= 1'b0;
            chout_reg  <= '0;
            lvlout_reg <= '0;
            anych_reg  <= 1'b0;
            done_reg   <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            fch_reg    <= fch_next;
            chg_reg    <= chg_next;
            strobe_reg <= strobe_next;
            chout_reg  <= chout_next;
            lvlout_reg <= lvlout_next;
            anych_reg  <= anych_next;
            done_reg   <= done_next;
            last_reg   <= last_next;
        end
    end

    // Channel state: cleared at reset, written one channel per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                level_reg[i]  <= '0;
                target_reg[i] <= '0;
                delay_reg[i]  <= '0;
                steps_reg[i]  <= '0;
            end
        end
        else
        begin
            if (lvl_we)
            begin
                level_reg[wr_idx] <= lvl_wdata;
            end
            if (tgt_we)
            begin
                target_reg[wr_idx] <= tgt_wdata;
            end
            if (dly_we)
            begin
                delay_reg[wr_idx] <= dly_wdata;
            end
            if (stp_we)
            begin
                steps_reg[wr_idx] <= stp_wdata;
            end
        end
    end

    assign strobe      = strobe_reg;
    assign channel_out = chout_reg;
    assign level_out   = lvlout_reg;
    assign any_changed = anych_reg;
    assign fade_done   = done_reg;
    assign last_result = last_reg;

`ifndef SYNTHESIS
    // A tick beat that is not the last leaves the sequencer mid-walk
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_result |-> busy)
        else $error("non-final beat emitted while idle");

    // The change flag only rides on the final beat of a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        any_changed |-> strobe && last_result)
        else $error("any_changed outside final tick beat");

    // Divider completion is only seen while a divide is awaited
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_FDIV) || (state_reg == S_TDIV))
        else $error("divider finished with no consumer");

    // An accepted tick always starts the channel walk
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (operation == mclf_pkg::OP_TICK) |=> busy)
        else $error("tick accepted but sequencer stayed idle");
`endif

endmodule
